FILE: rtl/pllw_pkg.sv
// Shared types and constants for the synthesizer register word generator.
// Used by every module in rtl/; depends on nothing.
package pllw_pkg;

   // Field widths
   localparam int WORD_W    = 32;
   localparam int FREQ_W    = 13;
   localparam int DEXP_W    = 3;
   localparam int N_W       = 8;
   localparam int FRAC_W    = 7;
   localparam int Y_W       = 12;
   localparam int REM_W     = 5;
   localparam int CSR_IDX_W = 3;
   localparam int SLOT_W    = 3;

   // Default depth of the command queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // Frequency limits and band edges, MHz
   localparam logic [FREQ_W-1:0] FREQ_MIN = 13'd100;
   localparam logic [FREQ_W-1:0] FREQ_MAX = 13'd6000;
   localparam logic [FREQ_W-1:0] BAND4_LO = 13'd177;
   localparam logic [FREQ_W-1:0] BAND3_LO = 13'd375;
   localparam logic [FREQ_W-1:0] BAND2_LO = 13'd750;
   localparam logic [FREQ_W-1:0] BAND1_LO = 13'd1500;
   localparam logic [FREQ_W-1:0] BAND0_LO = 13'd3000;

   // Divider math. y = (f << d) - VCO_BASE + Y_OFFSET stays in 32..3200,
   // so y / 25 is exact via reciprocal; n = N_BIAS + y / 25.
   localparam int VCO_BASE    = 3000;
   localparam int Y_OFFSET    = 200;
   localparam int STEP_MHZ    = 25;
   localparam int N_BASE      = 120;
   localparam int N_BIAS      = N_BASE - Y_OFFSET / STEP_MHZ;
   localparam int RECIP_SHIFT = 16;
   localparam logic [Y_W-1:0] RECIP_25 = Y_W'((2**RECIP_SHIFT + STEP_MHZ - 1) / STEP_MHZ);

   // Template masks
   localparam logic [WORD_W-1:0] KEEP_MASK0  = 32'h8000_0000;
   localparam logic [WORD_W-1:0] CLEAR_MASK4 = 32'hFF8F_FFFF;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_WORD0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD1      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD2      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD3      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_WORD4 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD5      = 3'd5;

   // CSR reset values
   localparam logic [WORD_W-1:0] RST_BASE_WORD0 = 32'h0040_0000;
   localparam logic [WORD_W-1:0] RST_WORD1      = 32'h2003_03E9;
   localparam logic [WORD_W-1:0] RST_WORD2      = 32'h2100_5E42;
   localparam logic [WORD_W-1:0] RST_WORD3      = 32'h0000_0133;
   localparam logic [WORD_W-1:0] RST_BASE_WORD4 = 32'h61DF_42FC;
   localparam logic [WORD_W-1:0] RST_WORD5      = 32'h0140_0005;

   // Output slot order within one pass: 5,4,3,2,1,0
   localparam logic [SLOT_W-1:0] SLOT_WORD5 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_WORD4 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_WORD3 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_WORD2 = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_WORD1 = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_WORD0 = 3'd5;

   // Classified request, front to back
   typedef struct packed {
      logic              range_error;
      logic [DEXP_W-1:0] dexp;
      logic [N_W-1:0]    n_int;
      logic [FRAC_W-1:0] frac;
   } cmd_type;

   // Register file contents
   typedef struct packed {
      logic [WORD_W-1:0] base_word0;
      logic [WORD_W-1:0] word1;
      logic [WORD_W-1:0] word2;
      logic [WORD_W-1:0] word3;
      logic [WORD_W-1:0] base_word4;
      logic [WORD_W-1:0] word5;
   } cfg_type;

endpackage

FILE: rtl/pllw_front.sv
// Front end: accepts a frequency request, picks the divider band and
// computes the integer/fractional divider. Depends on pllw_pkg.
module pllw_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pllw_pkg::FREQ_W-1:0]  req_target_mhz,
   output logic                         push,
   output pllw_pkg::cmd_type            push_cmd,
   input  logic                         q_full
);
   import pllw_pkg::*;

   localparam int SHIFT_W = FREQ_W + 5;

   logic              a_valid_ff, a_valid_in;
   logic              a_err_ff, a_err_in;
   logic [DEXP_W-1:0] a_dexp_ff, a_dexp_in;
   logic [Y_W-1:0]    a_y_ff, a_y_in;
   logic [SHIFT_W-1:0] shifted;
   logic [SHIFT_W-1:0] biased;
   logic              accept;
   logic [2*Y_W-1:0]  prod;
   logic [N_W-1:0]    quot;
   logic [Y_W-1:0]    quot25;
   logic [Y_W-1:0]    rem_full;
   logic [REM_W-1:0]  rem;

   // Stage holds one request; it moves on when the queue has room
   assign req_stall = a_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = a_valid_ff && !q_full;

   // Classify: range check, band pick, biased offset from VCO base
   always_comb begin
      a_err_in = (req_target_mhz < FREQ_MIN) || (req_target_mhz > FREQ_MAX);
      if (req_target_mhz < BAND4_LO) begin
         a_dexp_in = 3'd5;
      end else if (req_target_mhz < BAND3_LO) begin
         a_dexp_in = 3'd4;
      end else if (req_target_mhz < BAND2_LO) begin
         a_dexp_in = 3'd3;
      end else if (req_target_mhz < BAND1_LO) begin
         a_dexp_in = 3'd2;
      end else if (req_target_mhz < BAND0_LO) begin
         a_dexp_in = 3'd1;
      end else begin
         a_dexp_in = 3'd0;
      end
      shifted = SHIFT_W'(req_target_mhz) << a_dexp_in;
      biased  = shifted + SHIFT_W'(Y_OFFSET) - SHIFT_W'(VCO_BASE);
      a_y_in  = biased[Y_W-1:0];
   end

   // Stage register
   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (push) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_err_ff  <= a_err_in;
         a_dexp_ff <= a_dexp_in;
         a_y_ff    <= a_y_in;
      end
   end

   // Divide by 25: reciprocal multiply, then remainder by shift-add
   always_comb begin
      prod     = {{Y_W{1'b0}}, a_y_ff} * {{Y_W{1'b0}}, RECIP_25};
      quot     = prod[RECIP_SHIFT +: N_W];
      quot25   = {quot, 4'b0} + {1'b0, quot, 3'b0} + {4'b0, quot};
      rem_full = a_y_ff - quot25;
      rem      = rem_full[REM_W-1:0];
      push_cmd.range_error = a_err_ff;
      push_cmd.dexp        = a_dexp_ff;
      push_cmd.n_int       = quot + N_W'(N_BIAS);
      push_cmd.frac        = {rem, 2'b0} + {2'b0, rem};
   end

endmodule

FILE: rtl/pllw_queue.sv
// Small command queue between front and back, register based.
// Depends on pllw_pkg for the entry type.
module pllw_queue #(
   parameter int DEPTH = pllw_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pllw_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output pllw_pkg::cmd_type head,
   output logic              empty
);
   import pllw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/pllw_back.sv
// Back end: walks the six register slots twice per in-range command (one
// zero word on range error), drives the registered result channel. Depends on pllw_pkg.
module pllw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pllw_pkg::cfg_type           cfg,
   input  pllw_pkg::cmd_type           head,
   input  logic                        empty,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pllw_pkg::WORD_W-1:0] rsp_spi_word,
   output logic                        rsp_range_error,
   output logic                        rsp_last_word
);
   import pllw_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_err_ff, rsp_err_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic              second_ff, second_in;
   logic              out_free;
   logic              take;
   logic              last_slot;
   logic [WORD_W-1:0] word0;
   logic [WORD_W-1:0] word4;
   logic [WORD_W-1:0] slot_word;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign take      = out_free && !empty;
   assign last_slot = second_ff && (pos_ff == SLOT_WORD0);
   assign pop       = take && (head.range_error || last_slot);

   // Patched templates
   assign word0 = {cfg.base_word0[WORD_W-1], 8'b0, head.n_int, 5'b0, head.frac, 3'b0};
   assign word4 = {cfg.base_word4[WORD_W-1:23], head.dexp, cfg.base_word4[19:0]};

   // Slot select
   always_comb begin
      case (pos_ff)
         SLOT_WORD5: slot_word = cfg.word5;
         SLOT_WORD4: slot_word = word4;
         SLOT_WORD3: slot_word = cfg.word3;
         SLOT_WORD2: slot_word = cfg.word2;
         SLOT_WORD1: slot_word = cfg.word1;
         SLOT_WORD0: slot_word = word0;
         default:    slot_word = '0;
      endcase
   end

   // Sequencer and output register
   always_comb begin
      pos_in       = pos_ff;
      second_in    = second_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (take) begin
         rsp_valid_in = 1'b1;
         if (head.range_error) begin
            rsp_word_in = '0;
            rsp_err_in  = 1'b1;
            rsp_last_in = 1'b1;
         end else begin
            rsp_word_in = slot_word;
            rsp_err_in  = 1'b0;
            rsp_last_in = last_slot;
            if (last_slot) begin
               pos_in    = SLOT_WORD5;
               second_in = 1'b0;
            end else if (pos_ff == SLOT_WORD0) begin
               pos_in    = SLOT_WORD5;
               second_in = 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= SLOT_WORD5;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_spi_word    = rsp_word_ff;
   assign rsp_range_error = rsp_err_ff;
   assign rsp_last_word   = rsp_last_ff;

endmodule

FILE: rtl/pll_freq_to_register_words_core.sv
// Top level of the synthesizer register word generator: CSR file, front,
// command queue and back. Depends on pllw_pkg, pllw_front, pllw_queue, pllw_back.
//
// Usage:
//  - req channel: one word carries req_target_mhz; taken when req_valid is
//    high and req_stall low.
//  - rsp channel: a valid request in 100..6000 MHz yields twelve words, the
//    registers in order 5,4,3,2,1,0 and then again; rsp_last_word marks the
//    twelfth. Anything else yields one word of zero with rsp_range_error and
//    rsp_last_word set.
//  - csr channel: csr_index/csr_data written when csr_valid and csr_ready
//    are high; csr_ready is always high. Indexes above 5 are dropped. Write
//    only while no request is in flight.
//  - Path: a taken request passes the front stage register, then the queue,
//    then the output register, where its first word appears.
//  - Throughput: one word per cycle out of the back sequencer while rsp_stall
//    is low; the front keeps taking requests while the back works until the
//    queue fills.
//  - Reset (synchronous) restores the register defaults and empties the
//    pipeline; no clearing pass is needed.
//  - A stalled result holds; the back and then the front stall behind it.
module pll_freq_to_register_words_core #(
   parameter int QUEUE_DEPTH = pllw_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pllw_pkg::FREQ_W-1:0]    req_target_mhz,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pllw_pkg::WORD_W-1:0]    rsp_spi_word,
   output logic                           rsp_range_error,
   output logic                           rsp_last_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pllw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pllw_pkg::WORD_W-1:0]    csr_data
);
   import pllw_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    pop;
   cmd_type head;
   logic    q_empty;
   logic    csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // CSR file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BASE_WORD0: cfg_in.base_word0 = csr_data;
            CSR_WORD1:      cfg_in.word1      = csr_data;
            CSR_WORD2:      cfg_in.word2      = csr_data;
            CSR_WORD3:      cfg_in.word3      = csr_data;
            CSR_BASE_WORD4: cfg_in.base_word4 = csr_data;
            CSR_WORD5:      cfg_in.word5      = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_word0 <= RST_BASE_WORD0;
         cfg_ff.word1      <= RST_WORD1;
         cfg_ff.word2      <= RST_WORD2;
         cfg_ff.word3      <= RST_WORD3;
         cfg_ff.base_word4 <= RST_BASE_WORD4;
         cfg_ff.word5      <= RST_WORD5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pllw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_target_mhz (req_target_mhz),
      .push           (push),
      .push_cmd       (push_cmd),
      .q_full         (q_full)
   );

   pllw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty)
   );

   pllw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head            (head),
      .empty           (q_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_spi_word    (rsp_spi_word),
      .rsp_range_error (rsp_range_error),
      .rsp_last_word   (rsp_last_word)
   );

   // An error result is always the only word of its request
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_last_word)
      else $error("range error result without last_word");

   // An error result carries a zero word
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> (rsp_spi_word == '0))
      else $error("range error result with nonzero word");

   // The final word of a normal request is word 0, whose low bits are clear
   a_last_is_word0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_error && rsp_last_word |-> (rsp_spi_word[2:0] == 3'b000))
      else $error("last word of request is not register 0");

   // Reset empties the output register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
